FILE: rtl/gsb_pkg.sv
package gsb_pkg;

   localparam int NODE_DEPTH_DEF = 64;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 6;
   localparam int SWEEP_W = 16;
   localparam int STEP_W = 24;
   localparam int TOL_W = 62;
   localparam int PROD_W = 66;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 62;

   localparam logic signed [VALUE_W-1:0] Q24_ONE = 32'sh0100_0000;

   localparam logic [INDEX_W-1:0] RST_NODE_COUNT = 6'd63;
   localparam logic [STEP_W-1:0] RST_STEP_SIZE = 24'd266305;
   localparam logic [STEP_W-1:0] RST_INV_DIAGONAL = 24'd8388608;
   localparam logic [TOL_W-1:0] RST_TOLERANCE_SQ = '0;
   localparam logic [SWEEP_W-1:0] RST_MAX_ITERATIONS = 16'd1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NODE_COUNT,
      CSR_STEP_SIZE,
      CSR_INV_DIAGONAL,
      CSR_TOLERANCE_SQ,
      CSR_MAX_ITERATIONS
   } gsb_csr_index_type;

   typedef struct packed {
      logic [INDEX_W-1:0] node_count;
      logic [STEP_W-1:0] step_size;
      logic [STEP_W-1:0] inv_diagonal;
      logic [TOL_W-1:0] tolerance_sq;
      logic [SWEEP_W-1:0] max_iterations;
   } gsb_cfg_type;

   typedef struct packed {
      logic start;
      logic init_mul;
      logic init_wr;
      logic load_rd;
      logic load_win;
      logic upd_rd;
      logic upd_mul;
      logic upd_rnd;
      logic last_wr;
      logic iter_inc;
      logic finish_conv;
      logic out_start;
      logic out_rd;
      logic out_next;
   } gsb_cmd_type;

   typedef struct packed {
      logic idx_eq_m;
      logic idx_eq_m1;
      logic tol_met;
      logic cap_next;
   } gsb_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_MUL,
      ST_INIT_WR,
      ST_LOAD0,
      ST_LOAD1,
      ST_READ,
      ST_MUL,
      ST_RND,
      ST_LAST,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_CHECK,
      ST_OUT_READ,
      ST_OUT_SHOW
   } gsb_state_type;

   // Round a Q.48 product to Q8.24, ties toward plus infinity, then saturate.
   function automatic logic signed [VALUE_W-1:0] q24_round(input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W-1:0] y;
      logic signed [PROD_W-25:0] r;
      y = x + 66'sd8388608;
      r = y[PROD_W-1:24];
      if (r > 42'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (r < -(42'sd2147483648)) begin
         return 32'sh8000_0000;
      end else begin
         return r[VALUE_W-1:0];
      end
   endfunction

endpackage

FILE: rtl/gsb_csr_regs.sv
module gsb_csr_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gsb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gsb_pkg::CSR_DATA_W-1:0]      csr_data,
   output gsb_pkg::gsb_cfg_type                cfg
);
   import gsb_pkg::*;

   gsb_cfg_type cfg_ff;
   gsb_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NODE_COUNT:     cfg_in.node_count = csr_data[INDEX_W-1:0];
            CSR_STEP_SIZE:      cfg_in.step_size = csr_data[STEP_W-1:0];
            CSR_INV_DIAGONAL:   cfg_in.inv_diagonal = csr_data[STEP_W-1:0];
            CSR_TOLERANCE_SQ:   cfg_in.tolerance_sq = csr_data[TOL_W-1:0];
            CSR_MAX_ITERATIONS: cfg_in.max_iterations = csr_data[SWEEP_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_count <= RST_NODE_COUNT;
         cfg_ff.step_size <= RST_STEP_SIZE;
         cfg_ff.inv_diagonal <= RST_INV_DIAGONAL;
         cfg_ff.tolerance_sq <= RST_TOLERANCE_SQ;
         cfg_ff.max_iterations <= RST_MAX_ITERATIONS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/gsb_datapath.sv
module gsb_datapath #(
   parameter int NODE_DEPTH = gsb_pkg::NODE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gsb_pkg::gsb_cfg_type                  cfg,
   input  gsb_pkg::gsb_cmd_type                  cmd,
   input  logic [gsb_pkg::VALUE_W-1:0]           in_value,
   output gsb_pkg::gsb_status_type               status,
   output logic [gsb_pkg::INDEX_W-1:0]           out_index,
   output logic [gsb_pkg::VALUE_W-1:0]           out_value,
   output logic [gsb_pkg::SWEEP_W-1:0]           out_sweeps,
   output logic                                  out_conv,
   output logic                                  out_last
);
   import gsb_pkg::*;

   localparam int AW = $clog2(NODE_DEPTH);
   localparam logic [INDEX_W:0] M_MAX = (INDEX_W + 1)'(NODE_DEPTH - 1);

   logic signed [VALUE_W-1:0] node_store [NODE_DEPTH];

   logic [AW-1:0] m_ff, m_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [SWEEP_W-1:0] cap_ff, cap_in;
   logic [SWEEP_W-1:0] iter_ff, iter_in;
   logic conv_ff, conv_in;
   logic signed [VALUE_W-1:0] b_ff, b_in;
   logic signed [VALUE_W-1:0] f_ff, f_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [VALUE_W-1:0] rd_ff;
   logic signed [VALUE_W-1:0] x0_ff, x0_in;
   logic signed [VALUE_W-1:0] left_ff, left_in;
   logic signed [VALUE_W-1:0] cur_ff, cur_in;
   logic signed [VALUE_W-1:0] nxt_ff, nxt_in;
   logic signed [VALUE_W:0] d_ff, d_in;
   logic d_vld_ff, d_vld_in;
   logic [2*VALUE_W-1:0] sq_ff, sq_in;
   logic sq_sat_ff, sq_sat_in;
   logic sq_vld_ff, sq_vld_in;
   logic [2*VALUE_W-1:0] eps_ff, eps_in;

   logic [INDEX_W:0] nc_wide;
   logic [INDEX_W:0] m_clamp;
   logic signed [VALUE_W:0] mul_a;
   logic signed [VALUE_W-1:0] mul_b;
   logic signed [2*VALUE_W:0] mul_p;
   logic signed [VALUE_W-1:0] round_val;
   logic mem_we;
   logic [AW-1:0] mem_waddr;
   logic signed [VALUE_W-1:0] mem_wdata;
   logic mem_re;
   logic [AW-1:0] mem_raddr;
   logic [VALUE_W:0] d_abs;
   logic [2*VALUE_W-1:0] sq_term;
   logic [2*VALUE_W:0] eps_sum;
   logic [SWEEP_W:0] iter_next;

   // Active node count, clamped to at least 2 and at most the top index the store can hold.
   always_comb begin
      nc_wide = {1'b0, cfg.node_count};
      if (nc_wide < (INDEX_W + 1)'(2)) begin
         m_clamp = (INDEX_W + 1)'(2);
      end else if (nc_wide > M_MAX) begin
         m_clamp = M_MAX;
      end else begin
         m_clamp = nc_wide;
      end
   end

   // One shared multiplier: start profile during setup, neighbor sum during sweeps.
   always_comb begin
      if (cmd.init_mul) begin
         mul_a = {f_ff[VALUE_W-1], f_ff};
         mul_b = b_ff;
      end else begin
         mul_a = {left_ff[VALUE_W-1], left_ff} + {rd_ff[VALUE_W-1], rd_ff};
         mul_b = $signed({8'b0, cfg.inv_diagonal});
      end
      mul_p = mul_a * mul_b;
   end

   assign round_val = q24_round(prod_ff);

   assign mem_we = cmd.init_wr | cmd.upd_rnd | cmd.last_wr;
   assign mem_waddr = idx_ff;
   assign mem_wdata = cmd.last_wr ? left_ff : round_val;
   assign mem_re = cmd.load_rd | cmd.upd_rd | cmd.out_rd;

   always_comb begin
      if (cmd.load_rd) begin
         mem_raddr = AW'(1);
      end else if (cmd.upd_rd) begin
         mem_raddr = AW'(idx_ff + 1'b1);
      end else begin
         mem_raddr = idx_ff;
      end
   end

   assign d_abs = d_ff[VALUE_W] ? (VALUE_W + 1)'(-d_ff) : (VALUE_W + 1)'(d_ff);
   assign sq_term = sq_sat_ff ? '1 : sq_ff;
   assign eps_sum = {1'b0, eps_ff} + {1'b0, sq_term};
   assign iter_next = {1'b0, iter_ff} + 1'b1;

   always_comb begin
      m_in = m_ff;
      idx_in = idx_ff;
      cap_in = cap_ff;
      iter_in = iter_ff;
      conv_in = conv_ff;
      b_in = b_ff;
      f_in = f_ff;
      prod_in = prod_ff;
      x0_in = x0_ff;
      left_in = left_ff;
      cur_in = cur_ff;
      nxt_in = nxt_ff;
      d_in = {mem_wdata[VALUE_W-1], mem_wdata} - {cur_ff[VALUE_W-1], cur_ff};
      d_vld_in = cmd.upd_rnd | cmd.last_wr;
      sq_sat_in = d_abs[VALUE_W];
      sq_in = d_abs[VALUE_W-1:0] * d_abs[VALUE_W-1:0];
      sq_vld_in = d_vld_ff;
      eps_in = eps_ff;

      if (cmd.start) begin
         m_in = AW'(m_clamp);
         cap_in = (cfg.max_iterations == '0) ? SWEEP_W'(1) : cfg.max_iterations;
         idx_in = '0;
         iter_in = '0;
         conv_in = 1'b0;
         b_in = $signed(in_value);
         f_in = Q24_ONE;
      end
      if (cmd.init_mul) begin
         prod_in = {mul_p[2*VALUE_W], mul_p};
         f_in = f_ff - $signed({8'b0, cfg.step_size});
      end
      if (cmd.init_wr) begin
         idx_in = AW'(idx_ff + 1'b1);
         if (idx_ff == '0) begin
            x0_in = round_val;
         end
      end
      if (cmd.load_win) begin
         left_in = x0_ff;
         cur_in = rd_ff;
         idx_in = AW'(1);
         eps_in = '0;
      end
      if (cmd.upd_mul) begin
         prod_in = {mul_p[2*VALUE_W], mul_p};
         nxt_in = rd_ff;
      end
      if (cmd.upd_rnd) begin
         left_in = round_val;
         cur_in = nxt_ff;
         idx_in = AW'(idx_ff + 1'b1);
      end
      if (sq_vld_ff) begin
         eps_in = eps_sum[2*VALUE_W] ? '1 : eps_sum[2*VALUE_W-1:0];
      end
      if (cmd.iter_inc) begin
         iter_in = iter_next[SWEEP_W-1:0];
      end
      if (cmd.finish_conv) begin
         conv_in = 1'b1;
      end
      if (cmd.out_start) begin
         idx_in = '0;
      end
      if (cmd.out_next) begin
         idx_in = AW'(idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_store[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= node_store[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
      idx_ff <= idx_in;
      cap_ff <= cap_in;
      iter_ff <= iter_in;
      conv_ff <= conv_in;
      b_ff <= b_in;
      f_ff <= f_in;
      prod_ff <= prod_in;
      x0_ff <= x0_in;
      left_ff <= left_in;
      cur_ff <= cur_in;
      nxt_ff <= nxt_in;
      d_ff <= d_in;
      sq_ff <= sq_in;
      sq_sat_ff <= sq_sat_in;
      eps_ff <= eps_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
         sq_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= d_vld_in;
         sq_vld_ff <= sq_vld_in;
      end
   end

   assign status.idx_eq_m = (idx_ff == m_ff);
   assign status.idx_eq_m1 = (idx_ff == AW'(m_ff - 1'b1));
   assign status.tol_met = (eps_ff <= {2'b0, cfg.tolerance_sq});
   assign status.cap_next = (iter_next >= {1'b0, cap_ff});

   assign out_index = INDEX_W'(idx_ff);
   assign out_value = rd_ff;
   assign out_sweeps = iter_ff;
   assign out_conv = conv_ff;
   assign out_last = (idx_ff == m_ff);

   // Writes never land past the last active node.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_waddr <= m_ff))
      else $error("node store write beyond active nodes");

   // The error sum is cleared only once the squaring pipeline has drained.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_win |-> (!d_vld_ff && !sq_vld_ff))
      else $error("error sum cleared with squares in flight");

   // The right-neighbor read of a sweep stays inside the active nodes.
   assert property (@(posedge clock) disable iff (reset)
      cmd.upd_rd |-> (idx_ff < m_ff))
      else $error("sweep read past the last node");

endmodule

FILE: rtl/gsb_controller.sv
module gsb_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  gsb_pkg::gsb_status_type     status,
   output gsb_pkg::gsb_cmd_type        cmd
);
   import gsb_pkg::*;

   gsb_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_INIT_MUL;
            end
         end
         ST_INIT_MUL: state_in = ST_INIT_WR;
         ST_INIT_WR: begin
            state_in = status.idx_eq_m ? ST_LOAD0 : ST_INIT_MUL;
         end
         ST_LOAD0: state_in = ST_LOAD1;
         ST_LOAD1: state_in = ST_READ;
         ST_READ: state_in = ST_MUL;
         ST_MUL: state_in = ST_RND;
         ST_RND: begin
            state_in = status.idx_eq_m1 ? ST_LAST : ST_READ;
         end
         ST_LAST: state_in = ST_DRAIN1;
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.tol_met || status.cap_next) begin
               state_in = ST_OUT_READ;
            end else begin
               state_in = ST_LOAD0;
            end
         end
         ST_OUT_READ: state_in = ST_OUT_SHOW;
         ST_OUT_SHOW: begin
            if (rsp_tready) begin
               state_in = status.idx_eq_m ? ST_IDLE : ST_OUT_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start = req_tvalid;
         end
         ST_INIT_MUL: cmd.init_mul = 1'b1;
         ST_INIT_WR: cmd.init_wr = 1'b1;
         ST_LOAD0: cmd.load_rd = 1'b1;
         ST_LOAD1: cmd.load_win = 1'b1;
         ST_READ: cmd.upd_rd = 1'b1;
         ST_MUL: cmd.upd_mul = 1'b1;
         ST_RND: cmd.upd_rnd = 1'b1;
         ST_LAST: cmd.last_wr = 1'b1;
         ST_CHECK: begin
            if (status.tol_met) begin
               cmd.finish_conv = 1'b1;
               cmd.out_start = 1'b1;
            end else begin
               cmd.iter_inc = 1'b1;
               cmd.out_start = status.cap_next;
            end
         end
         ST_OUT_READ: cmd.out_rd = 1'b1;
         ST_OUT_SHOW: begin
            rsp_tvalid = 1'b1;
            cmd.out_next = rsp_tready;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A new boundary value is never taken while results are still going out.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while a result beat is pending");

   // Once a solve starts, the input side stays closed on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input reopened right after a start");

   // Setup and sweep never contend for the shared multiplier or index counter.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.init_mul, cmd.upd_mul, cmd.init_wr, cmd.upd_rnd, cmd.out_next}))
      else $error("conflicting datapath commands");

endmodule

FILE: rtl/gauss_seidel_bar_heat_solver.sv
// With M active elements and K sweeps, a solve writes the start profile to nodes 0..M,
// runs K sweeps and then sends nodes 0..M out, each beat held while the output stalls.
// Throughput: one boundary value per solve; the next is taken once node M is delivered.
// Node memory and shared 33x32 multiplier make each node update read, multiply, round.
// Reset (synchronous, active high) restores the register defaults and idles the
// sequencer; the node store is not cleared, every solve writes it before reading.
module gauss_seidel_bar_heat_solver #(
   parameter int NODE_DEPTH = gsb_pkg::NODE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,   // boundary_value
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [55:0]                        rsp_tdata,   // node_index, node_value, sweep_count
   output logic                               rsp_tuser,   // converged
   output logic                               rsp_tlast,   // last_node
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gsb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gsb_pkg::CSR_DATA_W-1:0]     csr_data
);
   import gsb_pkg::*;

   gsb_cfg_type cfg;
   gsb_cmd_type cmd;
   gsb_status_type status;
   logic [INDEX_W-1:0] out_index;
   logic [VALUE_W-1:0] out_value;
   logic [SWEEP_W-1:0] out_sweeps;

   gsb_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gsb_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gsb_datapath #(
      .NODE_DEPTH (NODE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .in_value   (req_tdata),
      .status     (status),
      .out_index  (out_index),
      .out_value  (out_value),
      .out_sweeps (out_sweeps),
      .out_conv   (rsp_tuser),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_sweeps, out_value, out_index};

endmodule

FILE: verif/tb_gauss_seidel_bar_heat_solver.sv
`timescale 1ns / 1ps

module tb_gauss_seidel_bar_heat_solver;
   import gsb_pkg::*;

   localparam int PERIOD = 10;
   localparam int RESET_CYCLES = 12;
   localparam int IDLE_LIMIT = 100000;
   localparam int RANDOM_ITEMS = 120;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES = 20;
   localparam int CSR_SPARE_FIRST = int'(CSR_MAX_ITERATIONS) + 1;
   localparam int CSR_SPARE_LAST = 2**CSR_IDX_W - 1;
   localparam logic signed [VALUE_W-1:0] BV_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] BV_MIN = 32'sh8000_0000;

   typedef struct {
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
      logic [SWEEP_W-1:0] sweeps;
      logic               conv;
      logic               last;
   } node_result_type;

   class bar_solve_scoreboard;
      gsb_cfg_type cfg;
      logic signed [VALUE_W-1:0] bar [NODE_DEPTH_DEF];
      node_result_type solved_nodes[$];
      int errors;
      int solves;
      int nodes_checked;
      int converged_solves;

      function new();
         cfg.node_count = RST_NODE_COUNT;
         cfg.step_size = RST_STEP_SIZE;
         cfg.inv_diagonal = RST_INV_DIAGONAL;
         cfg.tolerance_sq = RST_TOLERANCE_SQ;
         cfg.max_iterations = RST_MAX_ITERATIONS;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_NODE_COUNT: cfg.node_count = data[INDEX_W-1:0];
            CSR_STEP_SIZE: cfg.step_size = data[STEP_W-1:0];
            CSR_INV_DIAGONAL: cfg.inv_diagonal = data[STEP_W-1:0];
            CSR_TOLERANCE_SQ: cfg.tolerance_sq = data[TOL_W-1:0];
            CSR_MAX_ITERATIONS: cfg.max_iterations = data[SWEEP_W-1:0];
            default: ;
         endcase
      endfunction

      // Q.48 product to Q8.24: add half an LSB, floor, then clamp to 32 bits.
      function logic signed [VALUE_W-1:0] round_q24(longint x);
         longint y;
         longint r;
         y = x + 64'sd8388608;
         r = y >>> 24;
         if (r > 64'sd2147483647) return BV_MAX;
         if (r < -64'sd2147483648) return BV_MIN;
         return r[VALUE_W-1:0];
      endfunction

      function bit [63:0] sq_delta(longint nv, longint old);
         longint d;
         bit [63:0] a;
         d = nv - old;
         a = (d < 0) ? -d : d;
         if (a >= 64'h1_0000_0000) return '1;
         return a * a;
      endfunction

      function bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
         bit [64:0] s;
         s = a + b;
         return s[64] ? '1 : s[63:0];
      endfunction

      function int pending();
         return solved_nodes.size();
      endfunction

      function void note_boundary(logic signed [VALUE_W-1:0] b);
         int top;
         int m;
         int unsigned cap;
         int unsigned iter;
         longint f;
         longint s;
         logic signed [VALUE_W-1:0] nv;
         bit [63:0] err;
         bit conv;
         node_result_type e;
         top = cfg.node_count;
         if (top < 2) top = 2;
         if (top > NODE_DEPTH_DEF - 1) top = NODE_DEPTH_DEF - 1;
         cap = (cfg.max_iterations == 0) ? 1 : cfg.max_iterations;
         for (m = 0; m <= top; m++) begin
            f = 64'sd16777216 - longint'(m) * longint'(cfg.step_size);
            bar[m] = round_q24(f * longint'(b));
         end
         iter = 0;
         while (1) begin
            err = '0;
            for (m = 1; m < top; m++) begin
               s = longint'(bar[m-1]) + longint'(bar[m+1]);
               nv = round_q24(s * longint'(cfg.inv_diagonal));
               err = add_sat(err, sq_delta(nv, bar[m]));
               bar[m] = nv;
            end
            // The insulated end simply follows its neighbor.
            nv = bar[top-1];
            err = add_sat(err, sq_delta(nv, bar[top]));
            bar[top] = nv;
            if (err <= cfg.tolerance_sq) begin
               conv = 1'b1;
               break;
            end
            iter++;
            if (iter >= cap) begin
               conv = 1'b0;
               break;
            end
         end
         for (m = 0; m <= top; m++) begin
            e.index = m[INDEX_W-1:0];
            e.value = bar[m];
            e.sweeps = iter[SWEEP_W-1:0];
            e.conv = conv;
            e.last = (m == top);
            solved_nodes.push_back(e);
         end
         solves++;
         if (conv) converged_solves++;
      endfunction

      function void check_node(logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val,
                               logic [SWEEP_W-1:0] sw, logic conv, logic last);
         node_result_type e;
         if (solved_nodes.size() == 0) begin
            $error("node beat with nothing outstanding: node_index %0d", idx);
            errors++;
            return;
         end
         e = solved_nodes.pop_front();
         nodes_checked++;
         if (idx !== e.index) begin
            $error("node_index expected %0d actual %0d", e.index, idx);
            errors++;
         end
         if (val !== e.value) begin
            $error("node_value expected %h actual %h (node %0d)", e.value, val, e.index);
            errors++;
         end
         if (sw !== e.sweeps) begin
            $error("sweep_count expected %0d actual %0d", e.sweeps, sw);
            errors++;
         end
         if (conv !== e.conv) begin
            $error("converged expected %0b actual %0b", e.conv, conv);
            errors++;
         end
         if (last !== e.last) begin
            $error("last_node expected %0b actual %0b", e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [55:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   bar_solve_scoreboard sb = new();
   bit calm;
   int idle_cycles;
   int rsp_hold;
   int settings_used;
   int random_items;

   gauss_seidel_bar_heat_solver u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   // rsp_tdata: node_index [5:0], node_value [37:6], sweep_count [53:38].
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end else if (rsp_tvalid && rsp_tready) begin
            sb.check_node(rsp_tdata[5:0], rsp_tdata[37:6], rsp_tdata[53:38],
                          rsp_tuser, rsp_tlast);
         end
      end
   end

   // Receiver back-pressure: runs of ready and stalls, mostly short, now and then long.
   always @(posedge clock) begin
      int r;
      if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (calm || r < 60) begin
            rsp_tready <= 1'b1;
            rsp_hold = $urandom_range(0, 8);
         end else begin
            rsp_tready <= 1'b0;
            rsp_hold = (r < 92) ? $urandom_range(0, 3) : $urandom_range(20, 200);
         end
      end
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function logic [CSR_DATA_W-1:0] rand62();
      bit [63:0] w;
      w = {$urandom, $urandom};
      return w[CSR_DATA_W-1:0];
   endfunction

   function logic signed [VALUE_W-1:0] rand_boundary();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom;
      if (r < 80) return int'($urandom_range(0, 33554432)) - 16777216;
      case ($urandom_range(0, 4))
         0: return BV_MAX;
         1: return BV_MIN;
         2: return '0;
         3: return 32'sd1;
         default: return -32'sd1;
      endcase
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Unused upper data bits carry noise when asked, to show they are masked off.
   task automatic configure_solver(logic [INDEX_W-1:0] m, logic [STEP_W-1:0] step,
                                   logic [STEP_W-1:0] inv, logic [TOL_W-1:0] tol,
                                   logic [SWEEP_W-1:0] cap, bit noisy);
      logic [CSR_DATA_W-1:0] d;
      d = noisy ? rand62() : '0;
      d[INDEX_W-1:0] = m;
      write_csr(CSR_NODE_COUNT, d);
      d = noisy ? rand62() : '0;
      d[STEP_W-1:0] = step;
      write_csr(CSR_STEP_SIZE, d);
      d = noisy ? rand62() : '0;
      d[STEP_W-1:0] = inv;
      write_csr(CSR_INV_DIAGONAL, d);
      write_csr(CSR_TOLERANCE_SQ, tol);
      if (noisy && $urandom_range(0, 2) == 0)
         write_csr(CSR_IDX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)), rand62());
      d = noisy ? rand62() : '0;
      d[SWEEP_W-1:0] = cap;
      write_csr(CSR_MAX_ITERATIONS, d);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic send_boundary(logic signed [VALUE_W-1:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_boundary(b);
   endtask

   task automatic drain_solves();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic settle();
      drain_solves();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_setting();
      int r;
      int m;
      int m_eff;
      int n;
      logic [STEP_W-1:0] step;
      logic [STEP_W-1:0] inv;
      logic [TOL_W-1:0] tol;
      logic [SWEEP_W-1:0] cap;
      r = $urandom_range(0, 99);
      if (r < 5) m = $urandom_range(0, 1);
      else if (r < 70) m = $urandom_range(2, 8);
      else if (r < 90) m = $urandom_range(9, 24);
      else m = $urandom_range(25, 63);
      m_eff = (m < 2) ? 2 : m;
      // Big grids are slow per sweep, so they only get a few sweeps.
      if (m_eff > 24) cap = SWEEP_W'($urandom_range(1, 6));
      else if (m_eff > 8) cap = SWEEP_W'($urandom_range(1, 15));
      else cap = SWEEP_W'($urandom_range(0, 40));
      r = $urandom_range(0, 99);
      if (r < 50) step = STEP_W'(16777216 / m_eff);
      else if (r < 80) step = STEP_W'($urandom_range(0, 8388608));
      else step = STEP_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 60) inv = STEP_W'($urandom_range(24'h700000, 24'h800000));
      else if (r < 85) inv = STEP_W'($urandom_range(0, 24'h800000));
      else inv = STEP_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 30) tol = '0;
      else if (r < 65) tol = rand62() >> $urandom_range(20, 50);
      else tol = rand62();
      configure_solver(INDEX_W'(m), step, inv, tol, cap, 1'($urandom_range(0, 1)));
      calm = ($urandom_range(0, 4) == 0);
      n = $urandom_range(6, 14);
      repeat (n) begin
         if ($urandom_range(0, 9) == 0) drain_solves();
         send_boundary(rand_boundary());
         random_items++;
      end
      settle();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Smallest grid, flat initial profile, a zero cap that acts as one sweep.
      configure_solver(6'd2, 24'd0, 24'h800000, '0, 16'd0, 1'b0);
      send_boundary('0);
      send_boundary(BV_MAX);
      send_boundary(BV_MIN);
      send_boundary(-32'sd1);
      send_boundary(32'sd1);
      settle();

      // Largest grid with the natural mesh size.
      configure_solver(6'd63, 24'd266305, 24'h800000, '0, 16'd40, 1'b0);
      send_boundary(32'sh0100_0000);
      send_boundary(32'shFF00_0000);
      settle();

      // Too few elements, a mesh so coarse the start profile falls to zero at the far end, the
      // widest tolerance with the highest cap, and a write to a spare index.
      write_csr(CSR_IDX_W'(CSR_SPARE_LAST), rand62());
      configure_solver(6'd0, 24'h800000, 24'hFFFFFF, {TOL_W{1'b1}}, 16'hFFFF, 1'b0);
      send_boundary(32'sh0FFF_FFFF);
      send_boundary(-32'sh1000_0000);
      send_boundary(32'sh00AB_CDEF);
      send_boundary('0);
      settle();

      // Moderate tolerance so that runs stop on convergence after several sweeps.
      configure_solver(6'd4, 24'h400000, 24'h7F0000, 62'h1_0000_0000, 16'd1000, 1'b0);
      send_boundary(32'sh0100_0000);
      send_boundary(32'shFF80_0000);
      send_boundary(32'sh4000_0000);
      send_boundary(32'sd1);
      settle();

      configure_solver(6'd1, 24'h555555, 24'h7FFFFF, '0, 16'd300, 1'b0);
      send_boundary(32'sh0200_0000);
      send_boundary(-32'sh0080_0000);
      settle();

      while (random_items < RANDOM_ITEMS) random_setting();

      drain_solves();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d solves under %0d register settings, %0d node beats checked,",
               sb.solves, settings_used, sb.nodes_checked);
      $display("%0d solves stopped on tolerance and %0d on the sweep cap.",
               sb.converged_solves, sb.solves - sb.converged_solves);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
